// ----- hdl/urrf_pkg.sv -----
// Package with shared types and constants for the UART register block.
package urrf_pkg;

    // Kinds of input transfer.
    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_RECV  = 2'd2
    } op_t;

    // Register selector codes.
    localparam logic [3:0] REG_DR   = 4'd0;
    localparam logic [3:0] REG_RSR  = 4'd1;
    localparam logic [3:0] REG_FR   = 4'd2;
    localparam logic [3:0] REG_IBRD = 4'd3;
    localparam logic [3:0] REG_FBRD = 4'd4;
    localparam logic [3:0] REG_LCRH = 4'd5;
    localparam logic [3:0] REG_CTL  = 4'd6;
    localparam logic [3:0] REG_IFLS = 4'd7;
    localparam logic [3:0] REG_IM   = 4'd8;
    localparam logic [3:0] REG_RIS  = 4'd9;
    localparam logic [3:0] REG_MIS  = 4'd10;
    localparam logic [3:0] REG_ICR  = 4'd11;

    // Configuration register indexes.
    localparam logic CFG_TX_SINK = 1'b0;
    localparam logic CFG_IRQ     = 1'b1;

    // Bit positions in the flag and control registers.
    localparam int FR_RXFE_BIT   = 4;
    localparam int FR_RXFF_BIT   = 6;
    localparam int FR_TXFE_BIT   = 7;
    localparam int CTL_UARTEN_BIT = 0;
    localparam int CTL_TXE_BIT   = 8;
    localparam int RX_INT_BIT    = 4;

    localparam logic [31:0] CTL_RESET = 32'h0000_0300;

    // Requests from the register logic to the receive FIFO.
    typedef struct packed {
        logic       push;
        logic       pop;
        logic [7:0] push_data;
    } fifo_ctrl_t;

    // Status of the receive FIFO seen by the register logic.
    typedef struct packed {
        logic       empty;
        logic       full;
        logic [7:0] head_data;
    } fifo_stat_t;

    // One result item.
    typedef struct packed {
        logic [31:0] rdata;
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        irq_fire;
    } result_t;

endpackage

// ----- hdl/urrf_rx_fifo.sv -----
// Receive FIFO: storage array, head pointer, fill level and head-entry prefetch.
module urrf_rx_fifo #(
    parameter int RX_DEPTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  urrf_pkg::fifo_ctrl_t ctrl,
    output urrf_pkg::fifo_stat_t stat
);

    localparam int AW   = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
    localparam int LW   = $clog2(RX_DEPTH + 1);
    localparam int SUMW = LW + 1;

    logic [7:0]    store_mem [RX_DEPTH];
    logic [AW-1:0] head_reg;
    logic [AW-1:0] head_next;
    logic [AW-1:0] head_inc;
    logic [LW-1:0] level_reg;
    logic [LW-1:0] level_next;
    logic [SUMW-1:0] tail_sum;
    logic [AW-1:0] wr_addr;
    logic [7:0]    head_data_reg;

    // Pointer arithmetic with wrap at the depth.
    always_comb
    begin
        head_inc = (head_reg == AW'(RX_DEPTH - 1)) ? '0 : head_reg + 1'b1;
        head_next = ctrl.pop ? head_inc : head_reg;
        tail_sum = SUMW'(head_reg) + SUMW'(level_reg);
        if (tail_sum >= SUMW'(RX_DEPTH))
        begin
            wr_addr = AW'(tail_sum - SUMW'(RX_DEPTH));
        end
        else
        begin
            wr_addr = AW'(tail_sum);
        end
        level_next = level_reg;
        if (ctrl.push)
        begin
            level_next = level_reg + 1'b1;
        end
        else if (ctrl.pop)
        begin
            level_next = level_reg - 1'b1;
        end
    end

    // Pointer and level registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            level_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            level_reg <= level_next;
        end
    end

    // Storage write port.
    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            store_mem[wr_addr] <= ctrl.push_data;
        end
    end

    // Registered read of the entry that will be at the head next cycle;
    // a write to that same entry is forwarded.
    always_ff @(posedge clk)
    begin
        if (ctrl.push && (wr_addr == head_next))
        begin
            head_data_reg <= ctrl.push_data;
        end
        else
        begin
            head_data_reg <= store_mem[head_next];
        end
    end

    assign stat.empty     = (level_reg == '0);
    assign stat.full      = (level_reg == LW'(RX_DEPTH));
    assign stat.head_data = head_data_reg;

endmodule

// ----- hdl/urrf_regs.sv -----
// Register file of the UART: decode of reads and writes, receive handling, results.
module urrf_regs (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_en,
    input  logic                 cfg_addr,
    input  logic                 cfg_data,
    input  logic                 fire,
    input  logic [1:0]           op,
    input  logic [3:0]           reg_sel,
    input  logic [31:0]          wdata,
    input  logic [7:0]           rx_byte,
    input  urrf_pkg::fifo_stat_t fifo_stat,
    output urrf_pkg::fifo_ctrl_t fifo_ctrl,
    output urrf_pkg::result_t    result
);

    logic        tx_sink_reg;
    logic        irq_att_reg;
    logic [7:0]  last_data_reg;
    logic [7:0]  last_data_next;
    logic [15:0] baud_int_reg;
    logic [15:0] baud_int_next;
    logic [5:0]  baud_frac_reg;
    logic [5:0]  baud_frac_next;
    logic [31:0] line_ctrl_reg;
    logic [31:0] line_ctrl_next;
    logic [31:0] ctrl_reg;
    logic [31:0] ctrl_next;
    logic [31:0] ifls_reg;
    logic [31:0] ifls_next;
    logic [31:0] mask_reg;
    logic [31:0] mask_next;
    // Only the receive bit of the raw status can ever be set.
    logic        rx_int_reg;
    logic        rx_int_next;
    logic [7:0]  flags;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_sink_reg <= 1'b0;
            irq_att_reg <= 1'b0;
        end
        else if (cfg_en)
        begin
            unique case (cfg_addr)
                urrf_pkg::CFG_TX_SINK: tx_sink_reg <= cfg_data;
                urrf_pkg::CFG_IRQ:     irq_att_reg <= cfg_data;
                default:               ;
            endcase
        end
    end

    // The receive flag bits follow directly from the FIFO fill state; the transmit-empty flag is always set.
    always_comb
    begin
        flags = '0;
        flags[urrf_pkg::FR_TXFE_BIT] = 1'b1;
        flags[urrf_pkg::FR_RXFF_BIT] = fifo_stat.full;
        flags[urrf_pkg::FR_RXFE_BIT] = fifo_stat.empty;
    end

    // Decode of one transfer into result, register updates and FIFO requests.
    always_comb
    begin
        last_data_next = last_data_reg;
        baud_int_next  = baud_int_reg;
        baud_frac_next = baud_frac_reg;
        line_ctrl_next = line_ctrl_reg;
        ctrl_next      = ctrl_reg;
        ifls_next      = ifls_reg;
        mask_next      = mask_reg;
        rx_int_next    = rx_int_reg;
        fifo_ctrl      = '0;
        fifo_ctrl.push_data = rx_byte;
        result         = '0;

        unique case (op)
            urrf_pkg::OP_READ:
            begin
                unique case (reg_sel)
                    urrf_pkg::REG_DR:
                    begin
                        if (fifo_stat.empty)
                        begin
                            result.rdata = 32'(last_data_reg);
                        end
                        else
                        begin
                            result.rdata  = 32'(fifo_stat.head_data);
                            fifo_ctrl.pop = fire;
                        end
                    end
                    urrf_pkg::REG_FR:   result.rdata = 32'(flags);
                    urrf_pkg::REG_IBRD: result.rdata = 32'(baud_int_reg);
                    urrf_pkg::REG_FBRD: result.rdata = 32'(baud_frac_reg);
                    urrf_pkg::REG_LCRH: result.rdata = line_ctrl_reg;
                    urrf_pkg::REG_CTL:  result.rdata = ctrl_reg;
                    urrf_pkg::REG_IFLS: result.rdata = ifls_reg;
                    urrf_pkg::REG_IM:   result.rdata = mask_reg;
                    urrf_pkg::REG_RIS:
                        result.rdata[urrf_pkg::RX_INT_BIT] = rx_int_reg;
                    urrf_pkg::REG_MIS:
                        result.rdata[urrf_pkg::RX_INT_BIT] =
                            rx_int_reg & mask_reg[urrf_pkg::RX_INT_BIT];
                    default: result.rdata = '0;
                endcase
            end
            urrf_pkg::OP_WRITE:
            begin
                unique case (reg_sel)
                    urrf_pkg::REG_DR:
                    begin
                        last_data_next = wdata[7:0];
                        if (ctrl_reg[urrf_pkg::CTL_UARTEN_BIT] &&
                            ctrl_reg[urrf_pkg::CTL_TXE_BIT] && tx_sink_reg)
                        begin
                            result.tx_valid = 1'b1;
                            result.tx_byte  = wdata[7:0];
                        end
                    end
                    urrf_pkg::REG_IBRD: baud_int_next  = wdata[15:0];
                    urrf_pkg::REG_FBRD: baud_frac_next = wdata[5:0];
                    urrf_pkg::REG_LCRH: line_ctrl_next = wdata;
                    urrf_pkg::REG_CTL:  ctrl_next      = wdata;
                    urrf_pkg::REG_IFLS: ifls_next      = wdata;
                    urrf_pkg::REG_IM:   mask_next      = wdata;
                    urrf_pkg::REG_ICR:
                        rx_int_next = rx_int_reg & ~wdata[urrf_pkg::RX_INT_BIT];
                    default: ;
                endcase
            end
            urrf_pkg::OP_RECV:
            begin
                // A byte arriving at a full FIFO is dropped.
                if (!fifo_stat.full)
                begin
                    fifo_ctrl.push  = fire;
                    rx_int_next     = 1'b1;
                    result.irq_fire = irq_att_reg & mask_reg[urrf_pkg::RX_INT_BIT];
                end
            end
            default: ;
        endcase
    end

    // Control and status registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_data_reg <= '0;
            baud_int_reg  <= '0;
            baud_frac_reg <= '0;
            line_ctrl_reg <= '0;
            ctrl_reg      <= urrf_pkg::CTL_RESET;
            ifls_reg      <= '0;
            mask_reg      <= '0;
            rx_int_reg    <= 1'b0;
        end
        else if (fire)
        begin
            last_data_reg <= last_data_next;
            baud_int_reg  <= baud_int_next;
            baud_frac_reg <= baud_frac_next;
            line_ctrl_reg <= line_ctrl_next;
            ctrl_reg      <= ctrl_next;
            ifls_reg      <= ifls_next;
            mask_reg      <= mask_next;
            rx_int_reg    <= rx_int_next;
        end
    end

endmodule

// ----- hdl/uart_registers_with_rx_fifo.sv -----
// Top level of the UART register block with receive FIFO.
//
//  channel  direction  handshake           payload
//  in       input      in_valid/in_stall   op, reg_sel, wdata, rx_byte
//  out      output     out_valid/out_stall rdata, tx_valid, tx_byte, irq_fire
//  cfg      input      cfg_en              cfg_addr, cfg_data
//
// Every input transfer gives exactly one result, held in the result register.
// One transfer can be accepted per cycle while in_stall is low; the input register
// and the result register form the two stages, and the FIFO head entry is prefetched.
// A stalled result holds the pipeline; the input register still takes one more
// transfer while the result waits.
// Reset is asynchronous and active low; the FIFO array itself is not cleared.
module uart_registers_with_rx_fifo #(
    parameter int RX_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_en,
    input  logic        cfg_addr,
    input  logic        cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  op,
    input  logic [3:0]  reg_sel,
    input  logic [31:0] wdata,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] rdata,
    output logic        tx_valid,
    output logic [7:0]  tx_byte,
    output logic        irq_fire
);

    logic        s1_valid_reg;
    logic [1:0]  s1_op_reg;
    logic [3:0]  s1_sel_reg;
    logic [31:0] s1_wdata_reg;
    logic [7:0]  s1_byte_reg;
    logic        advance;
    logic        out_valid_reg;
    urrf_pkg::result_t    res;
    urrf_pkg::result_t    res_reg;
    urrf_pkg::fifo_ctrl_t fifo_ctrl;
    urrf_pkg::fifo_stat_t fifo_stat;

    // The item in the input register moves on when the result slot is free.
    assign advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !advance;

    // Input register valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_op_reg    <= op;
            s1_sel_reg   <= reg_sel;
            s1_wdata_reg <= wdata;
            s1_byte_reg  <= rx_byte;
        end
    end

    urrf_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_en    (cfg_en),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .fire      (advance),
        .op        (s1_op_reg),
        .reg_sel   (s1_sel_reg),
        .wdata     (s1_wdata_reg),
        .rx_byte   (s1_byte_reg),
        .fifo_stat (fifo_stat),
        .fifo_ctrl (fifo_ctrl),
        .result    (res)
    );

    urrf_rx_fifo #(
        .RX_DEPTH (RX_DEPTH)
    ) u_rx_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (fifo_ctrl),
        .stat  (fifo_stat)
    );

    // Result register valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign rdata     = res_reg.rdata;
    assign tx_valid  = res_reg.tx_valid;
    assign tx_byte   = res_reg.tx_byte;
    assign irq_fire  = res_reg.irq_fire;

endmodule

// ----- hdl/urrf_checker.sv -----
// Port-level checks for the UART register block and their binding.
module urrf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] rdata,
    input logic        tx_valid,
    input logic [7:0]  tx_byte,
    input logic        irq_fire
);

    // A result carries at most one kind of effect.
    a_one_effect: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(tx_valid && irq_fire))
        else $error("transmit and interrupt in one result");

    // Read data appears only on results without transmit or interrupt.
    a_rdata_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (rdata != 32'd0)) |-> (!tx_valid && !irq_fire))
        else $error("read data alongside another effect");

    // The transmit byte is zero unless a byte is sent.
    a_tx_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !tx_valid) |-> (tx_byte == 8'd0))
        else $error("transmit byte without transmit");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(rdata)
            && $stable(tx_valid) && $stable(tx_byte) && $stable(irq_fire)))
        else $error("stalled result changed");

    // Input is never refused while no result is pending downstream.
    a_no_stall_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid && $past(!out_valid)) |-> !in_stall)
        else $error("input stalled with empty output");

endmodule

bind uart_registers_with_rx_fifo urrf_checker u_urrf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .rdata     (rdata),
    .tx_valid  (tx_valid),
    .tx_byte   (tx_byte),
    .irq_fire  (irq_fire)
);
